>>> rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int BLOCKS    = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_W     = $clog2(BLOCKS);
    localparam int CNT_W     = $clog2(BLOCKS + 1);

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic REG_FIT_MODE      = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    localparam logic [CNT_W-1:0] BLOCKS_RESET = CNT_W'(BLOCKS);

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_NEXT  = 2'd2,
        FIT_WORST = 2'd3
    } t_fit_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

    typedef struct packed {
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_addr;
        logic [SIZE_BITS-1:0] wr_data;
        logic                 rd_en;
        logic [IDX_W-1:0]     rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic                 valid;
        logic                 allocated;
        logic [IDX_W-1:0]     chosen;
        logic [SIZE_BITS-1:0] remaining;
    } t_result;

endpackage

>>> rtl/fpba_mem.sv
// ----------------------------------------------------------------------------
// fpba_mem
// Free-size table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fpba_mem
    import fpba_pkg::*;
(
    input  logic                 i_clk,
    input  t_mem_req             i_req,
    output logic [SIZE_BITS-1:0] o_rd_data
);

    logic [SIZE_BITS-1:0] r_mem [BLOCKS];
    logic [SIZE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: loads sizes, scans the table one entry per cycle, writes back.
// ----------------------------------------------------------------------------
module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_fit_mode            i_fit_mode,
    input  logic [CNT_W-1:0]     i_blocks_in_use,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [3:0]           i_block_index,
    input  logic [15:0]          i_size_value,
    input  logic                 i_out_free,
    output t_result              o_res,
    output t_mem_req             o_mem_req,
    input  logic [SIZE_BITS-1:0] i_rd_data
);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_ptr;
    logic [SIZE_BITS-1:0] r_need;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_left;
    logic [IDX_W-1:0]     r_pos;
    logic [IDX_W-1:0]     r_dpos;
    logic                 r_dv;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_pick_size;

    logic                 accept;
    logic [CNT_W-1:0]     n_active;
    logic [IDX_W-1:0]     start_pos;
    logic [CNT_W-1:0]     pos_inc;
    logic [IDX_W-1:0]     pos_next;
    logic                 fits;
    logic                 take;
    logic                 issue;
    logic [SIZE_BITS-1:0] new_size;

    assign accept = i_in_valid && !o_in_stall;

    // 0 counts as one block, anything above the table as the whole table
    always_comb begin
        if (i_blocks_in_use == '0) begin
            n_active = CNT_W'(1);
        end else if (i_blocks_in_use > CNT_W'(BLOCKS)) begin
            n_active = CNT_W'(BLOCKS);
        end else begin
            n_active = i_blocks_in_use;
        end
    end

    always_comb begin
        if (i_fit_mode == FIT_NEXT && {1'b0, r_ptr} < n_active) begin
            start_pos = r_ptr;
        end else begin
            start_pos = '0;
        end
    end

    assign pos_inc  = {1'b0, r_pos} + CNT_W'(1);
    assign pos_next = (pos_inc < r_n) ? pos_inc[IDX_W-1:0] : '0;
    assign issue    = (r_state == S_SCAN) && (r_left != '0);
    assign new_size = r_pick_size - r_need;

    always_comb begin
        fits = i_rd_data >= r_need;
        case (i_fit_mode)
            FIT_BEST:  take = fits && (!r_found || i_rd_data < r_pick_size);
            FIT_WORST: take = fits && (!r_found || i_rd_data > r_pick_size);
            default:   take = fits && !r_found;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_func == FUNC_REQUEST) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_left == '0 && r_dv) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall = 1'b1;
        o_mem_req  = '0;
        o_res      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall        = 1'b0;
                o_mem_req.wr_en   = accept && i_func == FUNC_LOAD
                                    && {1'b0, i_block_index} < CNT_W'(BLOCKS);
                o_mem_req.wr_addr = i_block_index[IDX_W-1:0];
                o_mem_req.wr_data = i_size_value[SIZE_BITS-1:0];
            end
            S_SCAN: begin
                o_mem_req.rd_en   = issue;
                o_mem_req.rd_addr = r_pos;
            end
            S_UPD: begin
                o_mem_req.wr_en   = i_out_free && r_found;
                o_mem_req.wr_addr = r_pick;
                o_mem_req.wr_data = new_size;
                o_res.valid       = i_out_free;
                o_res.allocated   = r_found;
                o_res.chosen      = r_found ? r_pick : '0;
                o_res.remaining   = r_found ? new_size : '0;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_dv    <= issue;
            if (accept && i_func == FUNC_LOAD) begin
                r_ptr <= '0;
            end else if (r_state == S_UPD && i_out_free && r_found
                         && i_fit_mode == FIT_NEXT) begin
                r_ptr <= r_pick;
            end
            if (accept && i_func == FUNC_REQUEST) begin
                r_left  <= n_active;
                r_found <= 1'b0;
            end else begin
                if (issue) begin
                    r_left <= r_left - CNT_W'(1);
                end
                if (r_dv && take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_func == FUNC_REQUEST) begin
            r_need <= i_size_value[SIZE_BITS-1:0];
            r_n    <= n_active;
            r_pos  <= start_pos;
        end else if (issue) begin
            r_pos <= pos_next;
        end
        if (issue) begin
            r_dpos <= r_pos;
        end
        if (r_dv && take) begin
            r_pick      <= r_dpos;
            r_pick_size <= i_rd_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> !o_mem_req.wr_en)
        else $error("table written during a scan");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.rd_en |-> {1'b0, o_mem_req.rd_addr} < r_n)
        else $error("scan read beyond blocks in use");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_found) |-> {1'b0, r_pick} < r_n)
        else $error("chosen block beyond blocks in use");

    a_request_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_REQUEST) |=> r_state == S_SCAN && r_left != '0)
        else $error("request did not start a scan");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |=> r_state == S_IDLE)
        else $error("result not followed by idle");
`endif

endmodule

>>> rtl/fit_policy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Block allocator with first, best, next and worst fit over a free-size table.
// ----------------------------------------------------------------------------
// A load writes its size into the table and gives no result.
// A request scans the clamped blocks_in_use entries, reading one table entry
// per cycle from the memory port, then writes back and registers its result;
// the input stalls until that result enters the output register.
// Reset clears control, the next-fit pointer and the registers (fit_mode 0,
// blocks_in_use 16); the free-size table is not cleared and holds garbage.
module fit_policy_block_allocator_unit
    import fpba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [3:0]  i_block_index,
    input  logic [15:0] i_size_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_allocated,
    output logic [3:0]  o_chosen_block,
    output logic [15:0] o_remaining_size
);

    t_fit_mode            r_fit_mode;
    logic [CNT_W-1:0]     r_blocks_in_use;
    logic                 r_out_valid;
    logic                 r_allocated;
    logic [3:0]           r_chosen_block;
    logic [15:0]          r_remaining_size;

    logic                 cfg_wr;
    logic                 out_free;
    t_result              res;
    t_mem_req             mem_req;
    logic [SIZE_BITS-1:0] rd_data;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode      <= FIT_FIRST;
            r_blocks_in_use <= BLOCKS_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FIT_MODE:      r_fit_mode      <= t_fit_mode'(pwdata[1:0]);
                REG_BLOCKS_IN_USE: r_blocks_in_use <= pwdata[CNT_W-1:0];
                default:           r_fit_mode      <= r_fit_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FIT_MODE:      prdata = {30'd0, r_fit_mode};
            REG_BLOCKS_IN_USE: prdata = {{(32 - CNT_W){1'b0}}, r_blocks_in_use};
            default:           prdata = '0;
        endcase
    end

    fpba_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fit_mode      (r_fit_mode),
        .i_blocks_in_use (r_blocks_in_use),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_block_index   (i_block_index),
        .i_size_value    (i_size_value),
        .i_out_free      (out_free),
        .o_res           (res),
        .o_mem_req       (mem_req),
        .i_rd_data       (rd_data)
    );

    fpba_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // output register holds a transaction until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_allocated      <= res.allocated;
            r_chosen_block   <= 4'(res.chosen);
            r_remaining_size <= 16'(res.remaining);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_allocated      = r_allocated;
    assign o_chosen_block   = r_chosen_block;
    assign o_remaining_size = r_remaining_size;

endmodule

>>> verif/fit_policy_block_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit_tb
// Self-checking bench for the fit-policy block allocator. A queue of load and
// request transactions feeds a clocked driver, and a clocked monitor checks
// every result against a local model of the free-size table. The run covers
// all four placement policies and several block counts, including the
// clamped ones. Both channels idle at random.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit_tb;
    import fpba_pkg::*;

    localparam int PERIOD_HI   = 6;
    localparam int PERIOD_LO   = 6;
    localparam int SETTLE      = 24;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 120;

    typedef struct {
        logic        func;
        logic [3:0]  idx;
        logic [15:0] size;
    } alloc_item_t;

    typedef struct packed {
        logic        allocated;
        logic [3:0]  chosen;
        logic [15:0] remaining;
    } alloc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        in_func = 1'b0;
    logic [3:0]  in_index = '0;
    logic [15:0] in_size = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        out_alloc;
    logic [3:0]  out_block;
    logic [15:0] out_remain;

    // local copy of the allocator state and its registers
    logic [15:0] free_tbl [BLOCKS];
    logic [3:0]  nf_ptr;
    t_fit_mode   cur_mode;
    int unsigned cur_blocks;

    alloc_item_t   pending_items [$];
    alloc_result_t expected_allocs [$];
    alloc_item_t   drv_item;
    int            send_gap = 0;
    int            stall_hold = 0;
    int            err_cnt = 0;
    int            cycles = 0;
    bit            quiet = 1'b0;

    fit_policy_block_allocator_unit DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_func           (in_func),
        .i_block_index    (in_index),
        .i_size_value     (in_size),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_allocated      (out_alloc),
        .o_chosen_block   (out_block),
        .o_remaining_size (out_remain)
    );

    always begin
        #PERIOD_LO clk = 1'b1;
        #PERIOD_HI clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void apply_alloc(input alloc_item_t it);
        int n;
        int pick;
        int pos;
        alloc_result_t res;
        if (it.func == FUNC_LOAD) begin
            free_tbl[it.idx] = it.size;
            nf_ptr = '0;
            return;
        end
        n = (cur_blocks < 1) ? 1 : ((cur_blocks > BLOCKS) ? BLOCKS : cur_blocks);
        pick = -1;
        if (cur_mode == FIT_NEXT) begin
            // circular scan from the pointer, each block visited once
            pos = (nf_ptr < n) ? nf_ptr : 0;
            for (int i = 0; i < n; i++) begin
                if (pick < 0 && free_tbl[pos] >= it.size) pick = pos;
                pos = (pos + 1 < n) ? pos + 1 : 0;
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                if (free_tbl[i] >= it.size) begin
                    if (pick < 0) pick = i;
                    else if (cur_mode == FIT_BEST && free_tbl[i] < free_tbl[pick]) pick = i;
                    else if (cur_mode == FIT_WORST && free_tbl[i] > free_tbl[pick]) pick = i;
                end
            end
        end
        if (pick < 0) begin
            res = '{allocated: 1'b0, chosen: 4'd0, remaining: 16'd0};
        end else begin
            free_tbl[pick] = free_tbl[pick] - it.size;
            if (cur_mode == FIT_NEXT) nf_ptr = pick[3:0];
            res = '{allocated: 1'b1, chosen: pick[3:0], remaining: free_tbl[pick]};
        end
        expected_allocs.push_back(res);
    endfunction

    // driver: payload only moves when the slot is empty or just accepted
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) apply_alloc(drv_item);
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    drv_item = pending_items.pop_front();
                    in_func  <= drv_item.func;
                    in_index <= drv_item.idx;
                    in_size  <= drv_item.size;
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        alloc_result_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_allocs.size() == 0) begin
                    $display("%0t: unexpected result alloc=%0b block=%0d remain=%0d",
                             $time, out_alloc, out_block, out_remain);
                    err_cnt++;
                end else begin
                    want = expected_allocs.pop_front();
                    if (out_alloc !== want.allocated) begin
                        $display("%0t: allocated expected %0b actual %0b",
                                 $time, want.allocated, out_alloc);
                        err_cnt++;
                    end
                    if (out_block !== want.chosen) begin
                        $display("%0t: chosen_block expected %0d actual %0d",
                                 $time, want.chosen, out_block);
                        err_cnt++;
                    end
                    if (out_remain !== want.remaining) begin
                        $display("%0t: remaining_size expected %0d actual %0d",
                                 $time, want.remaining, out_remain);
                        err_cnt++;
                    end
                end
            end
            if (stall_hold > 0) begin
                stall_hold--;
                out_stall <= 1'b1;
            end else begin
                stall_hold = pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_item(input logic func, input logic [3:0] idx, input logic [15:0] size);
        alloc_item_t it;
        it.func = func;
        it.idx  = idx;
        it.size = size;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_allocs.size() != 0)
            @(negedge clk);
        // a trailing load gives no result, let it finish
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] load_size();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'(100 * $urandom_range(1, 3));  // equal sizes make ties
            4:       return 16'($urandom);
            default: return 16'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [15:0] req_size();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return free_tbl[$urandom_range(0, BLOCKS - 1)];  // exact fit
            default: return 16'($urandom_range(1, 600));
        endcase
    endfunction

    initial begin
        int blocks_vals [PHASES] = '{16, 1, 16, 0, 31, 5, 16, 2, 17, 16, 3, 9, 16, 12, 1, 16};
        int count;
        int k;
        logic [15:0] d_sizes [BLOCKS] = '{50, 300, 16'hFFFF, 300, 0, 1000, 200, 200,
                                         7, 4000, 300, 1, 16'h8000, 2, 999, 16'h7FFF};

        cur_mode   = FIT_FIRST;
        cur_blocks = 16;
        nf_ptr     = '0;
        for (int i = 0; i < BLOCKS; i++) free_tbl[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: fill every block, then exercise zero, exact, tie and failing requests
        for (int i = 0; i < BLOCKS; i++) push_item(FUNC_LOAD, i[3:0], d_sizes[i]);
        push_item(FUNC_REQUEST, 4'hF, 16'd0);
        push_item(FUNC_REQUEST, 4'h0, 16'd100);
        push_item(FUNC_REQUEST, 4'h5, 16'hFFFF);
        push_item(FUNC_REQUEST, 4'hA, 16'hFFFF);
        push_item(FUNC_REQUEST, 4'h3, 16'd250);
        push_item(FUNC_REQUEST, 4'h9, 16'h8001);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            apb_write({REG_FIT_MODE, 2'b00}, 32'(p % 4));
            cur_mode = t_fit_mode'(p % 4);
            apb_write({REG_BLOCKS_IN_USE, 2'b00}, 32'(blocks_vals[p]));
            cur_blocks = blocks_vals[p];
            quiet = (p % 5 == 2);
            @(negedge clk);

            count = 0;
            while (count < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0: begin
                        // noise: any field value at all
                        push_item(1'($urandom), 4'($urandom), 16'($urandom));
                        count++;
                    end
                    1: begin
                        // oversized requests that mostly fail
                        k = $urandom_range(1, 3);
                        repeat (k) push_item(FUNC_REQUEST, 4'($urandom),
                                             16'($urandom_range(50000, 65535)));
                        count += k;
                    end
                    default: begin
                        // refill a few blocks, then a run of requests
                        k = $urandom_range(1, 4);
                        repeat (k) push_item(FUNC_LOAD, 4'($urandom), load_size());
                        count += k;
                        k = $urandom_range(3, 12);
                        repeat (k) push_item(FUNC_REQUEST, 4'($urandom), req_size());
                        count += k;
                    end
                endcase
            end
            wait_drained();
        end

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
